@@ rtl/core/gcb_pkg.sv @@
// Package for the great circle bearing unit: widths, angle constants,
// the arctangent table, the CORDIC gain and the Q30 multiply helper.
// Depends on nothing.
`default_nettype none
package gcb_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int ANG_W = 64;
    localparam int ROT_W = 34;
    localparam int VEC_W = 40;
    localparam int OUT_W = 31;

    localparam longint PI_Q60      = 64'sh3243F6A8885A308D;
    localparam longint PI_Q58      = PI_Q60 >>> 2;
    localparam longint TWO_PI_Q58  = PI_Q60 >>> 1;
    localparam longint HALF_PI_Q58 = PI_Q60 >>> 3;
    localparam longint DEG_Q25     = (64'sd180 <<< 55) / (PI_Q60 >>> 30);
    localparam longint DEG_LIMIT   = 64'sd754974720;

    typedef struct packed {
        logic signed [ANG_W-1:0] ang;
        logic                    neg;
    } red_t;

    // quotient of two non-negative constants by shift and subtract
    function automatic longint quot(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q58 from the odd power series
    function automatic longint atan_q58(input int i);
        longint sum;
        longint t;
        sum = 0;
        if (i == 0) begin
            return (PI_Q60 + 64'sd8) >>> 4;
        end
        for (int k = 1; i * k < 63; k += 2) begin
            t = quot((64'sd1 <<< 62) >>> (i * k), longint'(k));
            if (((k >> 1) & 1) != 0) begin
                sum = sum - t;
            end else begin
                sum = sum + t;
            end
        end
        return (sum + 64'sd8) >>> 4;
    endfunction

    function automatic longint inv_gain(input int n);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = 64'sd1 <<< 30;
        y = 0;
        z = 0;
        for (int i = 0; i < n; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_q58(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_q58(i);
            end
            x = nx;
        end
        return (x > 0) ? quot(64'sd1 <<< 60, x) : (64'sd1 <<< 30);
    endfunction

    // bring an angle into [-pi/2, pi/2], flag a shift of pi
    function automatic red_t reduce(input logic [31:0] raw);
        red_t r;
        logic signed [ANG_W-1:0] a;
        a = {{2{raw[31]}}, raw, 30'b0};
        r.neg = 1'b0;
        if (a > PI_Q58) begin
            a = a - TWO_PI_Q58;
        end else if (a < -PI_Q58) begin
            a = a + TWO_PI_Q58;
        end
        if (a > HALF_PI_Q58) begin
            a = a - PI_Q58;
            r.neg = 1'b1;
        end else if (a < -HALF_PI_Q58) begin
            a = a + PI_Q58;
            r.neg = 1'b1;
        end
        r.ang = a;
        return r;
    endfunction

    function automatic logic signed [VEC_W-1:0] qmul(input logic signed [VEC_W-1:0] a,
                                                     input logic signed [VEC_W-1:0] b);
        logic signed [2*VEC_W-1:0] p;
        p = (2*VEC_W)'(a) * (2*VEC_W)'(b);
        p = p + ((2*VEC_W)'(1) <<< 29);
        return p[VEC_W+29:30];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/great_circle_bearing_unit.sv @@
// Top level of the great circle bearing unit: fully pipelined datapath.
// Depends on gcb_pkg.
//
// Takes one coordinate item per cycle and returns the initial bearing from local
// north in degrees times 2^22. An item passes through the rotation CORDIC chain,
// eight multiply and add stages, the vectoring CORDIC chain and the scaling and
// output stages. A stall on the result side holds the whole pipe.
`default_nettype none
module great_circle_bearing_unit #(
    parameter int CORDIC_STAGES = gcb_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_observer_lat,
    input  wire logic [31:0] s_observer_lon,
    input  wire logic [31:0] s_target_lat,
    input  wire logic [31:0] s_target_lon,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [gcb_pkg::OUT_W-1:0] m_heading
);
    localparam int N  = CORDIC_STAGES;
    localparam int AW = gcb_pkg::ANG_W;
    localparam int RW = gcb_pkg::ROT_W;
    localparam int VW = gcb_pkg::VEC_W;
    localparam longint INV_GAIN  = gcb_pkg::inv_gain(N);
    localparam longint NEG_LIMIT = -gcb_pkg::DEG_LIMIT;

    typedef logic signed [VW-1:0] vec_t;

    logic en;
    logic m_valid_reg;
    logic signed [gcb_pkg::OUT_W-1:0] m_heading_reg;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en && aresetn;
    assign m_valid   = m_valid_reg;
    assign m_heading = m_heading_reg;

    // rotation CORDIC, four lanes
    logic signed [RW-1:0] rx_reg [0:N][0:3];
    logic signed [RW-1:0] ry_reg [0:N][0:3];
    logic signed [AW-1:0] rz_reg [0:N][0:3];
    logic                 rneg_reg [0:N][0:3];
    logic                 rv_reg [0:N];

    gcb_pkg::red_t red [0:3];
    assign red[0] = gcb_pkg::reduce(s_observer_lat);
    assign red[1] = gcb_pkg::reduce(s_observer_lon);
    assign red[2] = gcb_pkg::reduce(s_target_lat);
    assign red[3] = gcb_pkg::reduce(s_target_lon);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg[0] <= 1'b0;
        end else if (en) begin
            rv_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                rx_reg[0][l]   <= INV_GAIN[RW-1:0];
                ry_reg[0][l]   <= '0;
                rz_reg[0][l]   <= red[l].ang;
                rneg_reg[0][l] <= red[l].neg;
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_rot
        localparam longint AT = gcb_pkg::atan_q58(g);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[g+1] <= 1'b0;
            end else if (en) begin
                rv_reg[g+1] <= rv_reg[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < 4; l++) begin
                    if (rz_reg[g][l] >= 0) begin
                        rx_reg[g+1][l] <= rx_reg[g][l] - (ry_reg[g][l] >>> g);
                        ry_reg[g+1][l] <= ry_reg[g][l] + (rx_reg[g][l] >>> g);
                        rz_reg[g+1][l] <= rz_reg[g][l] - AT;
                    end else begin
                        rx_reg[g+1][l] <= rx_reg[g][l] + (ry_reg[g][l] >>> g);
                        ry_reg[g+1][l] <= ry_reg[g][l] - (rx_reg[g][l] >>> g);
                        rz_reg[g+1][l] <= rz_reg[g][l] + AT;
                    end
                    rneg_reg[g+1][l] <= rneg_reg[g][l];
                end
            end
        end
    end

    // cosines and sines per lane
    vec_t cs_c [0:3];
    vec_t cs_s [0:3];
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            cs_c[l] = rneg_reg[N][l] ? -VW'(rx_reg[N][l]) : VW'(rx_reg[N][l]);
            cs_s[l] = rneg_reg[N][l] ? -VW'(ry_reg[N][l]) : VW'(ry_reg[N][l]);
        end
    end

    // vector stages
    logic p_v_reg [1:8];
    vec_t h1_reg [0:2];
    vec_t n1_reg [0:2];
    vec_t h2_reg [0:2];
    vec_t n2_reg [0:2];
    vec_t sq2_reg [0:2];
    vec_t cr2_reg [0:2];
    vec_t mx2_reg, my2_reg;
    vec_t h3_reg [0:2];
    vec_t pa3_reg [0:2];
    vec_t pb3_reg [0:2];
    vec_t mx3_reg, my3_reg, mz3_reg;
    vec_t h4_reg [0:2];
    vec_t b4_reg [0:2];
    vec_t mx4_reg, my4_reg, mz4_reg;
    vec_t h5_reg [0:2];
    vec_t d5_reg [0:2];
    vec_t c5_reg [0:5];
    vec_t h6_reg [0:2];
    vec_t c6_reg [0:2];
    vec_t dot6_reg;
    vec_t t7_reg [0:2];
    vec_t dot7_reg;
    vec_t trip8_reg;
    vec_t dot8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= 8; i++) begin
                p_v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            p_v_reg[1] <= rv_reg[N];
            for (int i = 2; i <= 8; i++) begin
                p_v_reg[i] <= p_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h1_reg[0] <= gcb_pkg::qmul(cs_c[0], cs_c[1]);
            h1_reg[1] <= gcb_pkg::qmul(cs_c[0], cs_s[1]);
            h1_reg[2] <= cs_s[0];
            n1_reg[0] <= gcb_pkg::qmul(cs_c[2], cs_c[3]);
            n1_reg[1] <= gcb_pkg::qmul(cs_c[2], cs_s[3]);
            n1_reg[2] <= cs_s[2];

            for (int i = 0; i < 3; i++) begin
                h2_reg[i]  <= h1_reg[i];
                n2_reg[i]  <= n1_reg[i];
                sq2_reg[i] <= gcb_pkg::qmul(h1_reg[i], h1_reg[i]);
                cr2_reg[i] <= gcb_pkg::qmul(h1_reg[i], n1_reg[i]);
            end
            mx2_reg <= -gcb_pkg::qmul(h1_reg[0], h1_reg[2]);
            my2_reg <= -gcb_pkg::qmul(h1_reg[1], h1_reg[2]);

            pa3_reg[0] <= gcb_pkg::qmul(n2_reg[0], sq2_reg[1] + sq2_reg[2]);
            pb3_reg[0] <= gcb_pkg::qmul(h2_reg[0], cr2_reg[1] + cr2_reg[2]);
            pa3_reg[1] <= gcb_pkg::qmul(n2_reg[1], sq2_reg[0] + sq2_reg[2]);
            pb3_reg[1] <= gcb_pkg::qmul(h2_reg[1], cr2_reg[0] + cr2_reg[2]);
            pa3_reg[2] <= gcb_pkg::qmul(n2_reg[2], sq2_reg[0] + sq2_reg[1]);
            pb3_reg[2] <= gcb_pkg::qmul(h2_reg[2], cr2_reg[0] + cr2_reg[1]);
            mx3_reg    <= mx2_reg;
            my3_reg    <= my2_reg;
            mz3_reg    <= sq2_reg[0] + sq2_reg[1];
            for (int i = 0; i < 3; i++) begin
                h3_reg[i] <= h2_reg[i];
                b4_reg[i] <= pa3_reg[i] - pb3_reg[i];
                h4_reg[i] <= h3_reg[i];
                h5_reg[i] <= h4_reg[i];
                h6_reg[i] <= h5_reg[i];
            end
            mx4_reg <= mx3_reg;
            my4_reg <= my3_reg;
            mz4_reg <= mz3_reg;

            d5_reg[0] <= gcb_pkg::qmul(mx4_reg, b4_reg[0]);
            d5_reg[1] <= gcb_pkg::qmul(my4_reg, b4_reg[1]);
            d5_reg[2] <= gcb_pkg::qmul(mz4_reg, b4_reg[2]);
            c5_reg[0] <= gcb_pkg::qmul(b4_reg[1], mz4_reg);
            c5_reg[1] <= gcb_pkg::qmul(b4_reg[2], my4_reg);
            c5_reg[2] <= gcb_pkg::qmul(b4_reg[2], mx4_reg);
            c5_reg[3] <= gcb_pkg::qmul(b4_reg[0], mz4_reg);
            c5_reg[4] <= gcb_pkg::qmul(b4_reg[0], my4_reg);
            c5_reg[5] <= gcb_pkg::qmul(b4_reg[1], mx4_reg);

            dot6_reg  <= d5_reg[0] + d5_reg[1] + d5_reg[2];
            c6_reg[0] <= c5_reg[0] - c5_reg[1];
            c6_reg[1] <= c5_reg[2] - c5_reg[3];
            c6_reg[2] <= c5_reg[4] - c5_reg[5];

            for (int i = 0; i < 3; i++) begin
                t7_reg[i] <= gcb_pkg::qmul(c6_reg[i], h6_reg[i]);
            end
            dot7_reg <= dot6_reg;

            trip8_reg <= t7_reg[0] + t7_reg[1] + t7_reg[2];
            dot8_reg  <= dot7_reg;
        end
    end

    // vectoring CORDIC
    vec_t                 ax_reg [0:N];
    vec_t                 ay_reg [0:N];
    logic signed [AW-1:0] az_reg [0:N];
    logic                 azero_reg [0:N];
    logic                 av_reg [0:N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            av_reg[0] <= 1'b0;
        end else if (en) begin
            av_reg[0] <= p_v_reg[8];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            azero_reg[0] <= (dot8_reg == '0) && (trip8_reg == '0);
            if (dot8_reg < 0) begin
                ax_reg[0] <= -dot8_reg;
                ay_reg[0] <= -trip8_reg;
                az_reg[0] <= (trip8_reg >= 0) ? gcb_pkg::PI_Q58 : -gcb_pkg::PI_Q58;
            end else begin
                ax_reg[0] <= dot8_reg;
                ay_reg[0] <= trip8_reg;
                az_reg[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_vec
        localparam longint AT = gcb_pkg::atan_q58(g);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                av_reg[g+1] <= 1'b0;
            end else if (en) begin
                av_reg[g+1] <= av_reg[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (ay_reg[g] >= 0) begin
                    ax_reg[g+1] <= ax_reg[g] + (ay_reg[g] >>> g);
                    ay_reg[g+1] <= ay_reg[g] - (ax_reg[g] >>> g);
                    az_reg[g+1] <= az_reg[g] + AT;
                end else begin
                    ax_reg[g+1] <= ax_reg[g] - (ay_reg[g] >>> g);
                    ay_reg[g+1] <= ay_reg[g] + (ax_reg[g] >>> g);
                    az_reg[g+1] <= az_reg[g] - AT;
                end
                azero_reg[g+1] <= azero_reg[g];
            end
        end
    end

    // scale to degrees, round and clamp
    logic signed [AW-1:0] zf;
    logic signed [AW-1:0] z28w;
    logic signed [AW-1:0] prod_reg;
    logic signed [AW-1:0] deg;
    logic                 f_v_reg;
    logic signed [gcb_pkg::OUT_W-1:0] m_heading_next;

    assign zf   = azero_reg[N] ? '0 : az_reg[N];
    assign z28w = (zf + (AW'(1) <<< 29)) >>> 30;
    assign deg  = (prod_reg + (AW'(1) <<< 30)) >>> 31;

    always_comb begin
        if (deg > gcb_pkg::DEG_LIMIT) begin
            m_heading_next = gcb_pkg::DEG_LIMIT[gcb_pkg::OUT_W-1:0];
        end else if (deg < NEG_LIMIT) begin
            m_heading_next = NEG_LIMIT[gcb_pkg::OUT_W-1:0];
        end else begin
            m_heading_next = deg[gcb_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_v_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            f_v_reg     <= av_reg[N];
            m_valid_reg <= f_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg      <= AW'(signed'(z28w[31:0])) * gcb_pkg::DEG_Q25;
            m_heading_reg <= m_heading_next;
        end
    end

`ifndef ASSERT_OFF
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (AW'(m_heading) <= gcb_pkg::DEG_LIMIT)
                 && (AW'(m_heading) >= NEG_LIMIT))
        else $error("heading out of range");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(f_v_reg) && $stable(av_reg[N]))
        else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
